>>> design/cfae_pkg.sv
// ----------------------------------------------------------------------------
// cfae_pkg
// Types, character codes and the hex digit helper for the CAN frame text
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfae_pkg;

   localparam int unsigned IdWidth      = 29;
   localparam int unsigned StdIdWidth   = 11;
   localparam int unsigned LenWidth     = 4;
   localparam int unsigned PayloadWidth = 64;
   localparam int unsigned PosWidth     = 5;

   localparam logic [LenWidth-1:0] MaxLen    = 4'd8;
   localparam logic [3:0]          ExtDigits = 4'd8;
   localparam logic [3:0]          StdDigits = 4'd3;

   localparam logic [7:0] CharData   = 8'h54;  // 'T'
   localparam logic [7:0] CharRemote = 8'h52;  // 'R'
   localparam logic [7:0] CaseBit    = 8'h20;
   localparam logic [7:0] CharZero   = 8'h30;  // '0'
   localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
   localparam logic [7:0] CharCr     = 8'h0d;
   localparam logic [3:0] NibbleMask = 4'hf;

   typedef struct packed {
      logic [IdWidth-1:0]      frame_id;
      logic                    extended;
      logic                    remote;
      logic [LenWidth-1:0]     length;
      logic [PayloadWidth-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0] ascii_byte;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib & NibbleMask};
      if (nib < 4'd10) begin
         hex_char = CharZero + wide;
      end else begin
         hex_char = CharUpperA + wide - 8'd10;
      end
   endfunction

endpackage

`default_nettype wire

>>> design/can_frame_to_ascii_encoder.sv
// ----------------------------------------------------------------------------
// can_frame_to_ascii_encoder
// Turns one CAN frame into its serial-line text, one ASCII byte per cycle,
// ending each run with a carriage return.
//
//   channel  signals                    transfer when
//   req      start, busy, req_frame     start high, busy low at clock edge
//   rsp      rsp_strobe, rsp_data       every cycle rsp_strobe is high
//
// A frame gives 6 to 27 bytes, one per cycle; the byte counter over the
// held frame sets the rate. busy falls in the cycle the closing carriage
// return is formed, so the next frame follows with no gap in the output.
// Synchronous reset clears the active flag, the byte position and the
// strobe. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_to_ascii_encoder
   import cfae_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_frame,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   req_type               frame_ff, frame_in;
   logic                  active_ff, active_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic [3:0]            digits;
   logic [PosWidth-1:0]   digits_w;
   logic [PosWidth-1:0]   last_pos;
   logic                  at_last;
   logic                  accept;
   logic [31:0]           id_wide;
   logic [2:0]            id_sel;
   logic [3:0]            pay_sel;
   logic [PosWidth-1:0]   pay_off;
   logic [PosWidth-1:0]   id_off;
   logic [7:0]            head;
   logic [LenWidth-1:0]   sat_len;

   assign digits   = frame_ff.extended ? ExtDigits : StdDigits;
   assign digits_w = {1'b0, digits};
   assign last_pos = digits_w + 5'd2 +
                     (frame_ff.remote ? 5'd0 : {frame_ff.length, 1'b0});
   assign at_last  = (pos_ff == last_pos);
   assign busy     = active_ff && !at_last;
   assign accept   = start && !busy;

   assign id_wide = {3'd0, frame_ff.frame_id};
   assign id_off  = digits_w - pos_ff;
   assign id_sel  = id_off[2:0];
   assign pay_off = pos_ff - digits_w - 5'd2;
   assign pay_sel = pay_off[3:0] ^ 4'd1;
   assign head    = (frame_ff.remote ? CharRemote : CharData) |
                    (frame_ff.extended ? 8'd0 : CaseBit);
   assign sat_len = (req_frame.length > MaxLen) ? MaxLen : req_frame.length;

   always_comb begin
      rsp_in.last = 1'b0;
      if (pos_ff == 5'd0) begin
         rsp_in.ascii_byte = head;
      end else if (pos_ff <= digits_w) begin
         rsp_in.ascii_byte = hex_char(id_wide[{id_sel, 2'b00} +: 4]);
      end else if (pos_ff == digits_w + 5'd1) begin
         rsp_in.ascii_byte = CharZero + {4'd0, frame_ff.length};
      end else if (at_last) begin
         rsp_in.ascii_byte = CharCr;
         rsp_in.last       = 1'b1;
      end else begin
         rsp_in.ascii_byte = hex_char(frame_ff.payload[{pay_sel, 2'b00} +: 4]);
      end
   end

   always_comb begin
      frame_in  = frame_ff;
      active_in = active_ff;
      pos_in    = pos_ff;
      strobe_in = active_ff;
      if (accept) begin
         frame_in.frame_id = req_frame.extended ? req_frame.frame_id :
            {{(IdWidth-StdIdWidth){1'b0}}, req_frame.frame_id[StdIdWidth-1:0]};
         frame_in.extended = req_frame.extended;
         frame_in.remote   = req_frame.remote;
         frame_in.length   = sat_len;
         frame_in.payload  = req_frame.payload;
         active_in         = 1'b1;
         pos_in            = '0;
      end else if (active_ff) begin
         pos_in = pos_ff + 5'd1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

>>> tb/tb_can_frame_to_ascii_encoder.sv
// ----------------------------------------------------------------------------
// tb_can_frame_to_ascii_encoder
// Drives CAN frames into the text encoder and checks every emitted byte
// against an in-bench encoder. Directed frames cover the identifier and
// payload extremes, remote frames and length saturation; a random phase
// follows with random gaps between frames.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_can_frame_to_ascii_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import cfae_pkg::*;

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned TailCycles    = 40;
   localparam int unsigned RandomFrames  = 420;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_frame = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type expected_text[$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      idle_on     = 1'b1;

   can_frame_to_ascii_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_frame  (req_frame),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CharZero + {4'd0, nib};
      end
      return CharUpperA + {4'd0, nib} - 8'd10;
   endfunction

   function automatic void queue_char(input logic [7:0] c, input logic l);
      rsp_type r;
      r.ascii_byte = c;
      r.last       = l;
      expected_text.push_back(r);
   endfunction

   // expected text of one frame
   function automatic void encode_frame(input req_type f);
      logic [LenWidth-1:0] count;
      logic [31:0]         id;
      logic [7:0]          head;
      logic [7:0]          data_byte;
      int                  digits;
      count = (f.length > MaxLen) ? MaxLen : f.length;
      head  = f.remote ? CharRemote : CharData;
      if (f.extended) begin
         id     = {{(32-IdWidth){1'b0}}, f.frame_id};
         digits = 8;
      end else begin
         head   = head | CaseBit;
         id     = {{(32-StdIdWidth){1'b0}}, f.frame_id[StdIdWidth-1:0]};
         digits = 3;
      end
      queue_char(head, 1'b0);
      for (int i = digits - 1; i >= 0; i--) begin
         queue_char(hex_ascii(id[i*4 +: 4]), 1'b0);
      end
      queue_char(CharZero + {4'd0, count}, 1'b0);
      if (!f.remote) begin
         for (int i = 0; i < int'(count); i++) begin
            data_byte = f.payload[i*8 +: 8];
            queue_char(hex_ascii(data_byte[7:4]), 1'b0);
            queue_char(hex_ascii(data_byte[3:0]), 1'b0);
         end
      end
      queue_char(CharCr, 1'b1);
   endfunction

   // check output bytes, then record the frame taken at this edge
   always @(posedge clock) begin : check_text
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_text.size() == 0) begin
               error_count++;
               $display("%0t: unexpected byte, expected none, actual %h last %b",
                        $realtime, rsp_data.ascii_byte, rsp_data.last);
            end else begin
               want = expected_text.pop_front();
               if (rsp_data.ascii_byte !== want.ascii_byte) begin
                  error_count++;
                  $display("%0t: ascii_byte mismatch, expected %h, actual %h",
                           $realtime, want.ascii_byte, rsp_data.ascii_byte);
               end
               if (rsp_data.last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch, expected %b, actual %b",
                           $realtime, want.last, rsp_data.last);
               end
            end
         end
         if (start && !busy) begin
            encode_frame(req_frame);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("FAIL can_frame_to_ascii_encoder");
         $finish;
      end
   end

   // one frame transfer; start stays high when the next frame follows at once
   task automatic send_frame(input logic [IdWidth-1:0] id, input logic ext,
                             input logic rtr, input logic [LenWidth-1:0] len,
                             input logic [PayloadWidth-1:0] data);
      req_type f;
      int      gap;
      f.frame_id = id;
      f.extended = ext;
      f.remote   = rtr;
      f.length   = len;
      f.payload  = data;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_frame <= f;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic test_extreme_ids();
      idle_on = 1'b0;
      send_frame(29'h0, 1'b1, 1'b0, 4'd0, 64'h0);
      send_frame(29'h1fffffff, 1'b1, 1'b0, 4'd8, 64'hffffffffffffffff);
      send_frame(29'h7ff, 1'b0, 1'b0, 4'd8, 64'h0);
      send_frame(29'h1ffff800, 1'b0, 1'b0, 4'd1, 64'h5a);
      send_frame(29'h1fffffff, 1'b0, 1'b0, 4'd3, 64'hffffffffff123456);
      send_frame(29'h0, 1'b0, 1'b0, 4'd0, 64'hffffffffffffffff);
      send_frame(29'h12345678 & 29'h1fffffff, 1'b1, 1'b0, 4'd2, 64'habcd);
   endtask

   task automatic test_remote_frames();
      idle_on = 1'b1;
      send_frame(29'h0, 1'b0, 1'b1, 4'd0, 64'h0);
      send_frame(29'h7ff, 1'b0, 1'b1, 4'd8, 64'hffffffffffffffff);
      send_frame(29'h1fffffff, 1'b1, 1'b1, 4'd8, 64'h0123456789abcdef);
      send_frame(29'h0abcdef, 1'b1, 1'b1, 4'd4, 64'hdeadbeef);
      send_frame(29'h155, 1'b0, 1'b1, 4'd15, 64'h1);
   endtask

   task automatic test_length_saturation();
      idle_on = 1'b0;
      send_frame(29'h123, 1'b0, 1'b0, 4'd9, 64'h0123456789abcdef);
      send_frame(29'h1abcdef0, 1'b1, 1'b0, 4'd15, 64'hfedcba9876543210);
      send_frame(29'h2aa, 1'b0, 1'b0, 4'd12, 64'ha5a5a5a5a5a5a5a5);
      send_frame(29'h0, 1'b1, 1'b1, 4'd10, 64'hffffffffffffffff);
   endtask

   task automatic test_payload_patterns();
      idle_on = 1'b1;
      send_frame(29'h555, 1'b0, 1'b0, 4'd8, 64'h0123456789abcdef);
      send_frame(29'h0aaaaaaa, 1'b1, 1'b0, 4'd8, 64'hfedcba9876543210);
      send_frame(29'h15555555, 1'b1, 1'b0, 4'd5, 64'hffffff0000000000);
      send_frame(29'h001, 1'b0, 1'b0, 4'd7, 64'h55aa55aa55aa55aa);
   endtask

   task automatic test_random_traffic();
      logic [LenWidth-1:0] len;
      logic [31:0]         rnd_id;
      logic [31:0]         rnd_ext;
      logic [31:0]         rnd_rtr;
      logic [31:0]         rnd_len;
      for (int n = 0; n < int'(RandomFrames); n++) begin
         if (n % 30 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 9) == 0) begin
            rnd_len = $urandom_range(9, 15);
         end else begin
            rnd_len = $urandom_range(0, 8);
         end
         len     = rnd_len[LenWidth-1:0];
         rnd_id  = $urandom;
         rnd_ext = $urandom_range(0, 1);
         rnd_rtr = $urandom_range(0, 1);
         send_frame(rnd_id[IdWidth-1:0], rnd_ext[0], rnd_rtr[0], len,
                    {$urandom, $urandom});
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_ids();
      test_remote_frames();
      test_length_saturation();
      test_payload_patterns();
      test_random_traffic();
      start <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("PASS can_frame_to_ascii_encoder");
      end else begin
         $display("FAIL can_frame_to_ascii_encoder");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
design/cfae_pkg.sv
design/can_frame_to_ascii_encoder.sv
tb/tb_can_frame_to_ascii_encoder.sv
